### src/rthp_pkg.sv
// ----------------------------------------------------------------------------
// rthp_pkg
// Shared types and constants for the transport header port parser: key text,
// ASCII codes, port counts and the layout of one result word.
// ----------------------------------------------------------------------------
package rthp_pkg;

    localparam int KEY_LEN  = 12;
    localparam int KEY_BITS = KEY_LEN * 8;

    localparam logic [KEY_BITS-1:0] KEY_CLIENT = "client_port=";
    localparam logic [KEY_BITS-1:0] KEY_SERVER = "server_port=";
    localparam logic [KEY_BITS-1:0] KEY_INTER  = "interleaved=";

    // Bit positions in the key candidate mask.
    localparam int CAND_CLIENT = 0;
    localparam int CAND_SERVER = 1;
    localparam int CAND_INTER  = 2;

    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    localparam logic [1:0] CNT_NONE   = 2'd0;
    localparam logic [1:0] CNT_SINGLE = 2'd1;
    localparam logic [1:0] CNT_RANGE  = 2'd2;

    localparam logic [7:0] TRANSPORT_MAX = 8'd255;

    // Result queue depth; a power of two, at least four.
    localparam int RES_FIFO_DEPTH = 8;

    typedef struct packed {
        logic [7:0]  transport_index;
        logic [15:0] cli_port;
        logic [1:0]  client_count;
        logic [15:0] srv_port;
        logic [1:0]  server_count;
        logic        is_interleaved;
        logic        header_done;
        logic        all_interleaved;
        logic [15:0] chosen_port;
        logic [1:0]  chosen_count;
    } t_result;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

### src/rthp_fifo.sv
// ----------------------------------------------------------------------------
// rthp_fifo
// Small result queue with two ordered write ports and one read port.
// ----------------------------------------------------------------------------
module rthp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr0,
    input  logic [WIDTH-1:0]           i_wdata0,
    input  logic                       i_wr1,
    input  logic [WIDTH-1:0]           i_wdata1,
    input  logic                       i_rd,
    output logic                       o_valid,
    output logic [WIDTH-1:0]           o_rdata,
    output logic [$clog2(DEPTH):0]     o_level
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [AW:0]      r_level, n_level;
    logic             w_pop;
    logic [AW-1:0]    w_wptr1;

    assign o_valid = (r_level != '0);
    assign o_rdata = r_mem[r_rptr];
    assign o_level = r_level;
    assign w_pop   = o_valid && i_rd;
    assign w_wptr1 = r_wptr + AW'(1);

    always_comb begin
        n_wptr  = r_wptr + AW'(i_wr0) + AW'(i_wr1);
        n_rptr  = r_rptr + AW'(w_pop);
        n_level = r_level + (AW+1)'(i_wr0) + (AW+1)'(i_wr1) - (AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_mem[r_wptr] <= i_wdata0;
        end
        if (i_wr1) begin
            r_mem[w_wptr1] <= i_wdata1;
        end
    end

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= (AW+1)'(DEPTH))
        else $error("result queue level above depth");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr1 |-> i_wr0)
        else $error("second write without first");
`endif

endmodule

### src/rthp_parser.sv
// ----------------------------------------------------------------------------
// rthp_parser
// Per-byte state update of the transport header scanner; yields up to two
// result words for each byte.
// ----------------------------------------------------------------------------
module rthp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_ch,
    input  logic             i_last,
    output rthp_pkg::t_push  o_push,
    output rthp_pkg::t_result o_res0,
    output rthp_pkg::t_result o_res1
);

    import rthp_pkg::*;

    localparam logic [1:0] VP_NONE   = 2'd0;
    localparam logic [1:0] VP_LEAD   = 2'd1;
    localparam logic [1:0] VP_DIGITS = 2'd2;
    localparam logic [1:0] VP_END    = 2'd3;

    typedef struct packed {
        logic        in_spec;
        logic [3:0]  key_pos;
        logic [2:0]  key_cand;
        logic [1:0]  vphase;
        logic [15:0] accum;
        logic        neg;
        logic        dash;
        logic [15:0] cur_cp;
        logic [1:0]  cur_cc;
        logic [15:0] cur_sp;
        logic [1:0]  cur_sc;
        logic        cur_int;
        logic        agg_int;
        logic [15:0] best_port;
        logic [1:0]  best_count;
        logic [7:0]  tcount;
    } t_state;

    localparam t_state ST_RESET = '{
        in_spec: 1'b1, key_pos: 4'd0, key_cand: 3'b111, vphase: VP_NONE,
        accum: 16'd0, neg: 1'b0, dash: 1'b0,
        cur_cp: 16'd0, cur_cc: CNT_NONE, cur_sp: 16'd0, cur_sc: CNT_NONE,
        cur_int: 1'b0, agg_int: 1'b1, best_port: 16'd0, best_count: CNT_NONE,
        tcount: 8'd0
    };

    t_state r_st, n_st;

    function automatic logic [7:0] key_byte(input logic [KEY_BITS-1:0] txt,
                                            input logic [3:0] pos);
        logic [6:0] base;
        base = 7'((KEY_LEN - 1 - int'(pos)) * 8);
        return txt[base +: 8];
    endfunction

    function automatic t_state clear_field(input t_state s);
        t_state t;
        t = s;
        t.key_pos  = '0;
        t.key_cand = 3'b111;
        t.vphase   = VP_NONE;
        t.accum    = '0;
        t.neg      = 1'b0;
        t.dash     = 1'b0;
        return t;
    endfunction

    function automatic t_state end_field(input t_state s);
        t_state      t;
        logic [15:0] v;
        logic [1:0]  cnt;
        t   = s;
        v   = s.neg ? (~s.accum + 16'd1) : s.accum;
        cnt = s.dash ? CNT_RANGE : CNT_SINGLE;
        if (!s.in_spec && s.vphase != VP_NONE) begin
            if (s.key_cand[CAND_CLIENT]) begin
                t.cur_cp = v;
                t.cur_cc = cnt;
            end else if (s.key_cand[CAND_SERVER]) begin
                t.cur_sp = v;
                t.cur_sc = cnt;
            end else if (s.key_cand[CAND_INTER]) begin
                t.cur_cp  = v;
                t.cur_cc  = cnt;
                t.cur_sp  = v;
                t.cur_sc  = cnt;
                t.cur_int = 1'b1;
            end
        end
        t.in_spec = 1'b0;
        return clear_field(t);
    endfunction

    function automatic t_state feed(input t_state s, input logic [7:0] ch);
        t_state     t;
        logic [7:0] lc;
        logic       is_digit;
        logic       is_blank;
        t        = s;
        lc       = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? ch + CASE_SHIFT : ch;
        is_digit = (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9);
        is_blank = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        if (s.in_spec) begin
            t = s;
        end else if (s.vphase == VP_NONE) begin
            if (s.key_cand != '0 && int'(s.key_pos) < KEY_LEN) begin
                if (lc != key_byte(KEY_CLIENT, s.key_pos)) t.key_cand[CAND_CLIENT] = 1'b0;
                if (lc != key_byte(KEY_SERVER, s.key_pos)) t.key_cand[CAND_SERVER] = 1'b0;
                if (lc != key_byte(KEY_INTER, s.key_pos))  t.key_cand[CAND_INTER]  = 1'b0;
                t.key_pos = s.key_pos + 4'd1;
                if (t.key_pos == 4'(KEY_LEN) && t.key_cand != '0) begin
                    t.vphase = VP_LEAD;
                end
            end
        end else begin
            if (ch == CH_DASH) begin
                t.dash = 1'b1;
            end
            if (s.vphase == VP_LEAD) begin
                if (is_blank) begin
                    t.vphase = VP_LEAD;
                end else if (ch == CH_PLUS || ch == CH_DASH) begin
                    t.neg    = (ch == CH_DASH);
                    t.vphase = VP_DIGITS;
                end else if (is_digit) begin
                    t.accum  = {12'd0, ch[3:0]};
                    t.vphase = VP_DIGITS;
                end else begin
                    t.vphase = VP_END;
                end
            end else if (s.vphase == VP_DIGITS) begin
                if (is_digit) begin
                    // Times ten as two shifts and an add, kept mod 65536.
                    t.accum = (s.accum << 3) + (s.accum << 1) + {12'd0, ch[3:0]};
                end else begin
                    t.vphase = VP_END;
                end
            end
        end
        return t;
    endfunction

    // Folds the finished transport into the header-wide flag and port choice.
    function automatic t_state fold(input t_state s);
        t_state t;
        t = s;
        t.agg_int = s.agg_int & s.cur_int;
        if (s.best_count < CNT_RANGE && s.cur_cc > s.best_count) begin
            t.best_count = s.cur_cc;
            t.best_port  = s.cur_cp;
        end
        return t;
    endfunction

    function automatic t_result make_result(input t_state s, input logic done);
        t_result r;
        r.transport_index = s.tcount;
        r.cli_port        = s.cur_cp;
        r.client_count    = s.cur_cc;
        r.srv_port        = s.cur_sp;
        r.server_count    = s.cur_sc;
        r.is_interleaved  = s.cur_int;
        r.header_done     = done;
        r.all_interleaved = done ? s.agg_int : 1'b0;
        r.chosen_port     = done ? s.best_port : 16'd0;
        r.chosen_count    = done ? s.best_count : CNT_NONE;
        return r;
    endfunction

    function automatic t_state new_transport(input t_state s);
        t_state t;
        t         = s;
        t.cur_cp  = '0;
        t.cur_cc  = CNT_NONE;
        t.cur_sp  = '0;
        t.cur_sc  = CNT_NONE;
        t.cur_int = 1'b0;
        t.in_spec = 1'b1;
        if (s.tcount < TRANSPORT_MAX) begin
            t.tcount = s.tcount + 8'd1;
        end
        return clear_field(t);
    endfunction

    always_comb begin
        t_state s;
        s      = r_st;
        o_push = '0;
        o_res0 = '0;
        o_res1 = '0;
        if (i_valid) begin
            if (i_ch == CH_COMMA) begin
                s            = fold(end_field(s));
                o_res0       = make_result(s, 1'b0);
                o_push.first = 1'b1;
                s            = new_transport(s);
            end else if (i_ch == CH_SEMI) begin
                s = end_field(s);
            end else begin
                s = feed(s, i_ch);
            end
            if (i_last) begin
                s = fold(end_field(s));
                if (o_push.first) begin
                    o_res1        = make_result(s, 1'b1);
                    o_push.second = 1'b1;
                end else begin
                    o_res0       = make_result(s, 1'b1);
                    o_push.first = 1'b1;
                end
                s = ST_RESET;
            end
        end
        n_st = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else begin
            r_st <= n_st;
        end
    end

`ifndef SYNTHESIS
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_last) |=> (r_st.tcount == 8'd0 && r_st.in_spec))
        else $error("header end did not restart the scanner");

    a_done_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.second |-> (o_res1.header_done && !o_res0.header_done))
        else $error("second word is not the final one");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.cur_cc != 2'd3) && (r_st.cur_sc != 2'd3) && (r_st.best_count != 2'd3))
        else $error("port count out of range");
`endif

endmodule

### src/rtsp_transport_header_port_parser_core.sv
// ----------------------------------------------------------------------------
// rtsp_transport_header_port_parser_core
// Throughput: one header byte per cycle while the result queue has room.
// Latency: a result word is offered from the clock edge after the one that
// takes its byte. Input stalls when the queue could not hold two words for
// the byte in the input register and two more for a new byte.
// Reset: synchronous, active low; clears the scanner and empties the queue.
// ----------------------------------------------------------------------------
module rtsp_transport_header_port_parser_core #(
    parameter int FIFO_DEPTH = rthp_pkg::RES_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_transport_index,
    output logic [15:0] o_cli_port,
    output logic [1:0]  o_client_count,
    output logic [15:0] o_srv_port,
    output logic [1:0]  o_server_count,
    output logic        o_is_interleaved,
    output logic        o_header_done,
    output logic        o_all_interleaved,
    output logic [15:0] o_chosen_port,
    output logic [1:0]  o_chosen_count
);

    import rthp_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int RW = $bits(t_result);

    logic          r_in_valid;
    logic [7:0]    r_ch;
    logic          r_last;
    t_push         w_push;
    t_result       w_res0, w_res1, w_out;
    logic [RW-1:0] w_rdata;
    logic [AW:0]   w_level;
    logic [AW+1:0] w_need;

    // A byte in the input register may still add two entries to the queue.
    assign w_need  = (AW+2)'(w_level) + {(AW+1)'(r_in_valid), 1'b0};
    assign o_ready = (w_need <= (AW+2)'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_valid && o_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    rthp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_ch    (r_ch),
        .i_last  (r_last),
        .o_push  (w_push),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    rthp_fifo #(
        .WIDTH (RW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr0    (w_push.first),
        .i_wdata0 (w_res0),
        .i_wr1    (w_push.second),
        .i_wdata1 (w_res1),
        .i_rd     (i_ready),
        .o_valid  (o_valid),
        .o_rdata  (w_rdata),
        .o_level  (w_level)
    );

    assign w_out             = t_result'(w_rdata);
    assign o_transport_index = w_out.transport_index;
    assign o_cli_port        = w_out.cli_port;
    assign o_client_count    = w_out.client_count;
    assign o_srv_port        = w_out.srv_port;
    assign o_server_count    = w_out.server_count;
    assign o_is_interleaved  = w_out.is_interleaved;
    assign o_header_done     = w_out.header_done;
    assign o_all_interleaved = w_out.all_interleaved;
    assign o_chosen_port     = w_out.chosen_port;
    assign o_chosen_count    = w_out.chosen_count;

endmodule

### sim/transport_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// transport_result_checker
// Watches both channels of the transport header port parser, predicts the
// result words from the accepted header bytes and compares them field by field.
// ----------------------------------------------------------------------------
module transport_result_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  rthp_pkg::t_result i_result,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_results_checked,
    output int                o_headers_closed
);

    import rthp_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        VAL_IDLE,
        VAL_LEAD,
        VAL_DIGITS,
        VAL_DONE
    } t_val_phase;

    localparam logic [KEY_BITS-1:0] KEY_TEXT [3] = '{KEY_CLIENT, KEY_SERVER, KEY_INTER};

    // Scanner state of the current field.
    logic       first_field;
    logic [3:0] key_pos;
    logic [2:0] key_live;
    t_val_phase val_phase;
    logic [15:0] val_acc;
    logic       val_neg;
    logic       val_dash;

    // Current transport and the header-wide summary.
    logic [15:0] cur_cport;
    logic [1:0]  cur_ccnt;
    logic [15:0] cur_sport;
    logic [1:0]  cur_scnt;
    logic        cur_il;
    logic        all_il;
    logic [15:0] best_port;
    logic [1:0]  best_cnt;
    logic [7:0]  tr_index;

    t_result expected_results[$];
    int      mismatches = 0;
    int      checked = 0;
    int      closed = 0;

    task automatic clear_value();
        key_pos   = '0;
        key_live  = 3'b111;
        val_phase = VAL_IDLE;
        val_acc   = '0;
        val_neg   = 1'b0;
        val_dash  = 1'b0;
    endtask

    task automatic clear_transport();
        cur_cport = '0;
        cur_ccnt  = CNT_NONE;
        cur_sport = '0;
        cur_scnt  = CNT_NONE;
        cur_il    = 1'b0;
    endtask

    task automatic clear_header();
        first_field = 1'b1;
        clear_value();
        clear_transport();
        all_il    = 1'b1;
        best_port = '0;
        best_cnt  = CNT_NONE;
        tr_index  = '0;
    endtask

    // A field ends at a semicolon, a comma or the last byte; a key whose value
    // was reached commits its port here.
    task automatic close_field();
        logic [15:0] port;
        logic [1:0]  cnt;
        if (!first_field && val_phase != VAL_IDLE) begin
            port = val_neg ? 16'd0 - val_acc : val_acc;
            cnt  = val_dash ? CNT_RANGE : CNT_SINGLE;
            if (key_live[CAND_CLIENT]) begin
                cur_cport = port;
                cur_ccnt  = cnt;
            end else if (key_live[CAND_SERVER]) begin
                cur_sport = port;
                cur_scnt  = cnt;
            end else if (key_live[CAND_INTER]) begin
                cur_cport = port;
                cur_ccnt  = cnt;
                cur_sport = port;
                cur_scnt  = cnt;
                cur_il    = 1'b1;
            end
        end
        first_field = 1'b0;
        clear_value();
    endtask

    task automatic scan_field_byte(logic [7:0] c);
        logic [7:0] lc;
        if (first_field)
            return;
        if (val_phase == VAL_IDLE) begin
            lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_SHIFT : c;
            if (key_live == 3'b000 || key_pos >= KEY_LEN)
                return;
            for (int k = 0; k < 3; k++) begin
                if (lc != KEY_TEXT[k][(KEY_LEN - 1 - key_pos) * 8 +: 8])
                    key_live[k] = 1'b0;
            end
            key_pos = key_pos + 4'd1;
            if (key_pos == KEY_LEN && key_live != 3'b000)
                val_phase = VAL_LEAD;
            return;
        end
        if (c == CH_DASH)
            val_dash = 1'b1;
        if (val_phase == VAL_LEAD) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                return;
            if (c == CH_PLUS || c == CH_DASH) begin
                val_neg   = (c == CH_DASH);
                val_phase = VAL_DIGITS;
            end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
                val_acc   = 16'(c - CH_DIGIT_0);
                val_phase = VAL_DIGITS;
            end else begin
                val_phase = VAL_DONE;
            end
        end else if (val_phase == VAL_DIGITS) begin
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
                val_acc = 16'(val_acc * 16'd10 + 16'(c - CH_DIGIT_0));
            else
                val_phase = VAL_DONE;
        end
    endtask

    task automatic push_result(logic done);
        t_result r;
        all_il = all_il & cur_il;
        if (best_cnt < CNT_RANGE && cur_ccnt > best_cnt) begin
            best_cnt  = cur_ccnt;
            best_port = cur_cport;
        end
        r.transport_index = tr_index;
        r.cli_port        = cur_cport;
        r.client_count    = cur_ccnt;
        r.srv_port        = cur_sport;
        r.server_count    = cur_scnt;
        r.is_interleaved  = cur_il;
        r.header_done     = done;
        r.all_interleaved = done ? all_il : 1'b0;
        r.chosen_port     = done ? best_port : 16'd0;
        r.chosen_count    = done ? best_cnt : CNT_NONE;
        expected_results.push_back(r);
    endtask

    task automatic predict_byte(logic [7:0] c, logic is_last);
        if (c == CH_COMMA) begin
            close_field();
            push_result(1'b0);
            clear_transport();
            first_field = 1'b1;
            clear_value();
            if (tr_index != TRANSPORT_MAX)
                tr_index = tr_index + 8'd1;
        end else if (c == CH_SEMI) begin
            close_field();
        end else begin
            scan_field_byte(c);
        end
        if (is_last) begin
            close_field();
            push_result(1'b1);
            clear_header();
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result %0d, %s expected %0d got %0d",
                         $time, checked, name, want, got);
        end
    endtask

    task automatic compare_result();
        t_result want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result word with none expected (index %0d, done %b)",
                         $time, i_result.transport_index, i_result.header_done);
            return;
        end
        want = expected_results.pop_front();
        checked++;
        if (want.header_done)
            closed++;
        check_field("transport_index", 16'(want.transport_index),
                    16'(i_result.transport_index));
        check_field("cli_port", want.cli_port, i_result.cli_port);
        check_field("client_count", 16'(want.client_count), 16'(i_result.client_count));
        check_field("srv_port", want.srv_port, i_result.srv_port);
        check_field("server_count", 16'(want.server_count), 16'(i_result.server_count));
        check_field("is_interleaved", 16'(want.is_interleaved),
                    16'(i_result.is_interleaved));
        check_field("header_done", 16'(want.header_done), 16'(i_result.header_done));
        check_field("all_interleaved", 16'(want.all_interleaved),
                    16'(i_result.all_interleaved));
        check_field("chosen_port", want.chosen_port, i_result.chosen_port);
        check_field("chosen_count", 16'(want.chosen_count), 16'(i_result.chosen_count));
    endtask

    initial begin
        clear_header();
    end

    // The output is compared before the input is predicted, so a word that
    // comes out in the same cycle as its byte goes in is caught.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_header();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                compare_result();
            if (i_in_valid && i_in_ready)
                predict_byte(i_ch, i_last);
        end
        o_mismatches      = mismatches;
        o_pending         = expected_results.size();
        o_results_checked = checked;
        o_headers_closed  = closed;
    end

endmodule

### sim/rtsp_transport_header_port_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtsp_transport_header_port_parser_core_tb
// Feeds Transport headers byte by byte, mostly well-formed with random keys,
// values, letter case and blanks, plus noise, and lets the checker compare
// every result word. Both sides idle at random; one long output stall forces
// the result queue to fill and the input to back up.
// ----------------------------------------------------------------------------
module rtsp_transport_header_port_parser_core_tb;
    import rthp_pkg::*;

    localparam int ITEM_TARGET  = 1150;
    localparam int MAX_GAP      = 4;
    localparam int LONG_STALL   = 300;
    localparam int STORM_LEN    = 270;
    localparam int DRAIN_CYCLES = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_ch;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_transport_index;
    logic [15:0] o_cli_port;
    logic [1:0]  o_client_count;
    logic [15:0] o_srv_port;
    logic [1:0]  o_server_count;
    logic        o_is_interleaved;
    logic        o_header_done;
    logic        o_all_interleaved;
    logic [15:0] o_chosen_port;
    logic [1:0]  o_chosen_count;

    int mismatches;
    int pending;
    int results_checked;
    int headers_closed;

    int  bytes_sent = 0;
    int  headers_sent = 0;
    bit  quiet_send = 0;
    bit  quiet_recv = 0;
    bit  stall_req = 0;
    bit  storm_done = 0;
    logic [7:0] header_bytes[$];

    string key_names[3] = '{"client_port=", "server_port=", "interleaved="};
    string first_fields[5] = '{"RTP/AVP", "RTP/AVP/TCP", "rtp/avp/udp", "", "x"};
    string plain_params[5] = '{"unicast", "mode=PLAY", "ttl=16", "destination=10.0.0.1",
                               "ssrc=1A2B"};

    rtsp_transport_header_port_parser_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_ch              (i_ch),
        .i_last            (i_last),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_transport_index (o_transport_index),
        .o_cli_port        (o_cli_port),
        .o_client_count    (o_client_count),
        .o_srv_port        (o_srv_port),
        .o_server_count    (o_server_count),
        .o_is_interleaved  (o_is_interleaved),
        .o_header_done     (o_header_done),
        .o_all_interleaved (o_all_interleaved),
        .o_chosen_port     (o_chosen_port),
        .o_chosen_count    (o_chosen_count)
    );

    transport_result_checker port_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_ch              (i_ch),
        .i_last            (i_last),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_result          ({o_transport_index, o_cli_port, o_client_count,
                             o_srv_port, o_server_count, o_is_interleaved,
                             o_header_done, o_all_interleaved, o_chosen_port,
                             o_chosen_count}),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_results_checked (results_checked),
        .o_headers_closed  (headers_closed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_byte(logic [7:0] c, logic is_last);
        int gap;
        if ($urandom_range(0, 31) == 0)
            quiet_send = !quiet_send;
        gap = quiet_send ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_ch    = c;
        i_last  = is_last;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_header();
        if (header_bytes.size() == 0)
            header_bytes.push_back("x");
        foreach (header_bytes[i])
            send_byte(header_bytes[i], i == header_bytes.size() - 1);
        headers_sent++;
        header_bytes.delete();
    endtask

    task automatic add_text(string s, bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
                c = c - CASE_SHIFT;
            header_bytes.push_back(c);
        end
    endtask

    task automatic add_digits(int n);
        repeat (n) header_bytes.push_back(CH_DIGIT_0 + 8'($urandom_range(0, 9)));
    endtask

    // Value after a key: optional blanks and sign, a number that may overflow
    // 16 bits, an optional range and optional trailing text.
    task automatic add_value();
        int pick;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 1) == 1)
                    header_bytes.push_back(CH_SPACE);
                else
                    header_bytes.push_back(8'($urandom_range(CH_TAB, CH_CR)));
            end
        end
        pick = $urandom_range(0, 5);
        if (pick == 0)
            header_bytes.push_back(CH_PLUS);
        else if (pick == 1)
            header_bytes.push_back(CH_DASH);
        pick = $urandom_range(0, 9);
        if (pick >= 1 && pick <= 5)
            add_text($sformatf("%0d", $urandom_range(0, 65535)), 0);
        else if (pick == 6)
            add_text($sformatf("%0d", $urandom), 0);
        else if (pick == 7)
            add_digits($urandom_range(6, 10));
        else if (pick == 8)
            add_text("0", 0);
        else if (pick == 9)
            add_text("x", 0);
        if ($urandom_range(0, 2) == 0) begin
            header_bytes.push_back(CH_DASH);
            add_digits($urandom_range(0, 5));
        end
        if ($urandom_range(0, 4) == 0)
            add_text($urandom_range(0, 1) ? "/x" : " 7", 0);
    endtask

    task automatic add_field();
        string s;
        int    k;
        k = $urandom_range(0, 2);
        s = key_names[k];
        case ($urandom_range(0, 9))
            0, 1: begin
                add_text(key_names[0], 1);
                add_value();
            end
            2, 3: begin
                add_text(key_names[1], 1);
                add_value();
            end
            4, 5: begin
                add_text(key_names[2], 1);
                add_value();
            end
            6: add_text(plain_params[$urandom_range(0, 4)], 0);
            // The field ends before the key is complete.
            7: add_text(s.substr(0, $urandom_range(0, KEY_LEN - 2)), 1);
            8: begin
                s[$urandom_range(0, KEY_LEN - 1)] = "x";
                add_text(s, 1);
                add_value();
            end
            default: begin
                repeat ($urandom_range(1, 6))
                    header_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic build_header();
        int n;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 16)) begin
                case ($urandom_range(0, 9))
                    0:       header_bytes.push_back(CH_COMMA);
                    1:       header_bytes.push_back(CH_SEMI);
                    default: header_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        n = $urandom_range(1, 3);
        for (int t = 0; t < n; t++) begin
            if (t > 0)
                header_bytes.push_back(CH_COMMA);
            add_text(first_fields[$urandom_range(0, 4)], 0);
            repeat ($urandom_range(0, 4)) begin
                header_bytes.push_back(CH_SEMI);
                add_field();
            end
        end
        if ($urandom_range(0, 7) == 0)
            header_bytes.push_back(CH_COMMA);
    endtask

    // Receiver: a random hold-off before each word, and once a long one so
    // that the result queue fills while the sender keeps offering bytes.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0)
                quiet_recv = !quiet_recv;
            gap = quiet_recv ? 0 : $urandom_range(0, MAX_GAP);
            if (stall_req) begin
                stall_req = 1'b0;
                gap = LONG_STALL;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_ch    = '0;
        i_last  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extreme bytes alone, a lone comma and a lone semicolon as the last
        // byte, then an upper-case interleaved range with blanks and a sign,
        // closed by a trailing comma.
        header_bytes.push_back(8'h00);
        send_header();
        header_bytes.push_back(8'hFF);
        send_header();
        header_bytes.push_back(CH_COMMA);
        send_header();
        header_bytes.push_back(CH_SEMI);
        send_header();
        add_text("a;INTERLEAVED=\t-9-,", 0);
        send_header();

        while (bytes_sent < ITEM_TARGET) begin
            if (!storm_done && bytes_sent > ITEM_TARGET / 3) begin
                // A run of commas saturates the transport index and, with the
                // receiver held off, backs the input up.
                stall_req = 1'b1;
                repeat (STORM_LEN) header_bytes.push_back(CH_COMMA);
                send_header();
                storm_done = 1'b1;
            end else begin
                build_header();
                send_header();
            end
        end
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d header bytes in %0d headers with random gaps and a %0d-cycle",
                 bytes_sent, headers_sent, LONG_STALL);
        $display("output stall; checked %0d transport words, %0d header ends, %0d mismatches.",
                 results_checked, headers_closed, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
src/rthp_pkg.sv
src/rthp_fifo.sv
src/rthp_parser.sv
src/rtsp_transport_header_port_parser_core.sv
sim/transport_result_checker.sv
sim/rtsp_transport_header_port_parser_core_tb.sv
